[design/e2c_pkg.sv]
// Shared types, constants and lookup functions for the epoch-to-calendar core.
`default_nettype none
package e2c_pkg;

	// Start of the year walk and the year's residues mod 4, 100 and 400
	localparam logic [11:0] FIRST_YEAR  = 12'd1970;
	localparam logic [1:0]  MOD4_INIT   = 2'd2;
	localparam logic [6:0]  MOD100_INIT = 7'd70;
	localparam logic [8:0]  MOD400_INIT = 9'd370;
	localparam logic [6:0]  MOD100_LAST = 7'd99;
	localparam logic [8:0]  MOD400_LAST = 9'd399;

	localparam logic [8:0]  YEAR_DAYS      = 9'd365;
	localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
	localparam logic [3:0]  MONTH_JAN      = 4'd0;
	localparam logic [3:0]  MONTH_FEB      = 4'd1;
	localparam logic [3:0]  MONTH_DEC      = 4'd11;

	// Division step codes, in the order the controller runs them
	localparam logic [1:0] DIV_SEC  = 2'd0;
	localparam logic [1:0] DIV_MIN  = 2'd1;
	localparam logic [1:0] DIV_HOUR = 2'd2;
	localparam logic [1:0] DIV_WEEK = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       mul;
		logic       fix;
		logic [1:0] div_sel;
		logic       year_step;
		logic       month_step;
		logic       out_load;
	} e2c_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic year_last;
		logic month_last;
	} e2c_status_t;

	// One result
	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [2:0]  weekday;
		logic [11:0] full_year;
		logic [3:0]  month_number;
		logic [4:0]  day_of_month;
	} e2c_res_t;

	// Divisor of each division step
	function automatic logic [5:0] div_divisor(input logic [1:0] sel);
		logic [5:0] d;
		unique case (sel)
			DIV_SEC:  d = 6'd60;
			DIV_MIN:  d = 6'd60;
			DIV_HOUR: d = 6'd24;
			default:  d = 6'd7;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor): the estimate is the quotient or one below it
	function automatic logic [31:0] div_recip(input logic [1:0] sel);
		logic [31:0] m;
		unique case (sel)
			DIV_SEC:  m = 32'd71582788;
			DIV_MIN:  m = 32'd71582788;
			DIV_HOUR: m = 32'd178956970;
			default:  m = 32'd613566756;
		endcase
		return m;
	endfunction

	// Day 0 was a Thursday
	function automatic logic [2:0] weekday_of_offset(input logic [2:0] r);
		logic [2:0] w;
		unique case (r)
			3'd0:    w = 3'd4;
			3'd1:    w = 3'd5;
			3'd2:    w = 3'd6;
			3'd3:    w = 3'd0;
			3'd4:    w = 3'd1;
			3'd5:    w = 3'd2;
			3'd6:    w = 3'd3;
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	// Days in month m (0 January), February by the leap flag
	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			MONTH_FEB: n = leap ? 5'd29 : 5'd28;
			4'd3:      n = 5'd30;
			4'd5:      n = 5'd30;
			4'd8:      n = 5'd30;
			4'd10:     n = 5'd30;
			default:   n = 5'd31;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

[design/e2c_in_if.sv]
// Request channel: valid/ready handshake carrying the epoch seconds.
`default_nettype none
interface e2c_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

[design/e2c_out_if.sv]
// Result channel: valid/ready handshake carrying the calendar fields.
`default_nettype none
interface e2c_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [2:0]  weekday;
	logic [11:0] full_year;
	logic [3:0]  month_number;
	logic [4:0]  day_of_month;

	modport source (output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output weekday, output full_year, output month_number,
		output day_of_month, input ready);
	modport sink (input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input weekday, input full_year, input month_number,
		input day_of_month, output ready);
endinterface
`default_nettype wire

[design/epoch_seconds_to_calendar_core.sv]
// Top level: epoch seconds to Gregorian date and time of day.
//
//   channel    | dir | payload                                     | handshake
//   timestamp  | in  | epoch_seconds[31:0]                         | valid/ready
//   calendar   | out | sec, min, hour, weekday, year, month, day   | valid/ready
//
// After accept, a request runs the four divisions, then walks Y whole years past
// 1970 (0..136) and M months (0..11) before the result is valid; the year-by-year
// walk is the longest part of a request.
// A new request is taken once the previous one is in the result register,
// even while that result still waits for calendar.ready.
// Reset (arst_n low) clears the controller and drops any pending result.
`default_nettype none
module epoch_seconds_to_calendar_core (
	input wire         clk,
	input wire         arst_n,
	e2c_in_if.sink     timestamp,
	e2c_out_if.source  calendar
);
	import e2c_pkg::*;

	e2c_cmd_t    cmd;
	e2c_status_t status;
	e2c_res_t    res;

	e2c_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (timestamp.valid),
		.in_ready  (timestamp.ready),
		.out_valid (calendar.valid),
		.out_ready (calendar.ready),
		.status    (status),
		.cmd       (cmd)
	);

	e2c_datapath u_dp (
		.clk           (clk),
		.epoch_seconds (timestamp.epoch_seconds),
		.cmd           (cmd),
		.status        (status),
		.res           (res)
	);

	// Drive result fields
	assign calendar.second_of_minute = res.second_of_minute;
	assign calendar.minute_of_hour   = res.minute_of_hour;
	assign calendar.hour_of_day      = res.hour_of_day;
	assign calendar.weekday          = res.weekday;
	assign calendar.full_year        = res.full_year;
	assign calendar.month_number     = res.month_number;
	assign calendar.day_of_month     = res.day_of_month;

endmodule
`default_nettype wire

[design/e2c_datapath.sv]
// Datapath: reciprocal divider, year and month walk, result register.
`default_nettype none
module e2c_datapath (
	input  wire                  clk,
	input  wire  [31:0]          epoch_seconds,
	input  e2c_pkg::e2c_cmd_t    cmd,
	output e2c_pkg::e2c_status_t status,
	output e2c_pkg::e2c_res_t    res
);
	import e2c_pkg::*;

	logic [31:0] x_q;
	logic [31:0] prod_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [1:0]  mod4_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	logic [3:0]  month_q;
	e2c_res_t    res_q;

	logic [5:0]  divisor;
	logic [31:0] recip;
	logic [63:0] product;
	logic [31:0] q_times_d;
	logic [31:0] r_est;
	logic        adjust;
	logic [31:0] q_fix;
	logic [31:0] r_fix;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	// Estimate quotient by reciprocal, then fix it with one compare
	assign divisor   = div_divisor(cmd.div_sel);
	assign recip     = div_recip(cmd.div_sel);
	assign product   = {32'd0, x_q} * {32'd0, recip};
	assign q_times_d = prod_q * {26'd0, divisor};
	assign r_est     = x_q - q_times_d;
	assign adjust    = (r_est >= {26'd0, divisor});
	assign q_fix     = adjust ? prod_q + 32'd1 : prod_q;
	assign r_fix     = adjust ? r_est - {26'd0, divisor} : r_est;

	// Gregorian leap rule from the tracked residues
	assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
	assign mlen = month_length(month_q, leap);

	assign status.year_last  = (days_q < {7'd0, ylen});
	assign status.month_last = (days_q < {11'd0, mlen}) || (month_q == MONTH_DEC);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= epoch_seconds;
			year_q   <= FIRST_YEAR;
			mod4_q   <= MOD4_INIT;
			mod100_q <= MOD100_INIT;
			mod400_q <= MOD400_INIT;
			month_q  <= MONTH_JAN;
		end
		if (cmd.mul) begin
			prod_q <= product[63:32];
		end
		if (cmd.fix) begin
			unique case (cmd.div_sel)
				DIV_SEC: begin
					sec_q <= r_fix[5:0];
					x_q   <= q_fix;
				end
				DIV_MIN: begin
					min_q <= r_fix[5:0];
					x_q   <= q_fix;
				end
				DIV_HOUR: begin
					hour_q <= r_fix[4:0];
					x_q    <= q_fix;
					days_q <= q_fix[15:0];
				end
				default: begin
					wday_q <= weekday_of_offset(r_fix[2:0]);
				end
			endcase
		end
		// Advance one whole year
		if (cmd.year_step) begin
			days_q   <= days_q - {7'd0, ylen};
			year_q   <= year_q + 12'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == MOD100_LAST) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == MOD400_LAST) ? 9'd0 : mod400_q + 9'd1;
		end
		// Advance one whole month
		if (cmd.month_step) begin
			days_q  <= days_q - {11'd0, mlen};
			month_q <= month_q + 4'd1;
		end
		// Capture the finished result
		if (cmd.out_load) begin
			res_q.second_of_minute <= sec_q;
			res_q.minute_of_hour   <= min_q;
			res_q.hour_of_day      <= hour_q;
			res_q.weekday          <= wday_q;
			res_q.full_year        <= year_q;
			res_q.month_number     <= month_q + 4'd1;
			res_q.day_of_month     <= days_q[4:0] + 5'd1;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

[design/e2c_controller.sv]
// Controller: sequences divisions, year walk, month walk and result handoff.
`default_nettype none
module e2c_controller (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  e2c_pkg::e2c_status_t status,
	output e2c_pkg::e2c_cmd_t    cmd
);
	import e2c_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_FIX   = 3'd2;
	localparam logic [2:0] S_YEAR  = 3'd3;
	localparam logic [2:0] S_MONTH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [1:0] div_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the state
	always_comb begin
		cmd         = '0;
		cmd.div_sel = div_q;
		unique case (state_q)
			S_IDLE:  cmd.load       = in_valid;
			S_MUL:   cmd.mul        = 1'b1;
			S_FIX:   cmd.fix        = 1'b1;
			S_YEAR:  cmd.year_step  = !status.year_last;
			S_MONTH: cmd.month_step = !status.month_last;
			S_DONE:  cmd.out_load   = !out_valid_q || out_ready;
			default: cmd            = '0;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_q       <= DIV_SEC;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						div_q   <= DIV_SEC;
					end
				end
				S_MUL: state_q <= S_FIX;
				S_FIX: begin
					if (div_q == DIV_WEEK) begin
						state_q <= S_YEAR;
					end else begin
						div_q   <= div_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_YEAR: begin
					if (status.year_last) state_q <= S_MONTH;
				end
				S_MONTH: begin
					if (status.month_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Hold the result until taken
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[design/e2c_checker.sv]
// Port-level checker for the epoch-to-calendar core and its bind.
`default_nettype none
module e2c_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [5:0]  second_of_minute,
	input wire [5:0]  minute_of_hour,
	input wire [4:0]  hour_of_day,
	input wire [2:0]  weekday,
	input wire [11:0] full_year,
	input wire [3:0]  month_number,
	input wire [4:0]  day_of_month
);

	// Drop ready for the cycle after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while previous one still in work");

	// Time of day and weekday stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
			&& (hour_of_day < 5'd24) && (weekday < 3'd7))
		else $error("time of day or weekday out of range");

	// Date stays in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (full_year >= 12'd1970) && (full_year <= 12'd2106)
			&& (month_number >= 4'd1) && (month_number <= 4'd12)
			&& (day_of_month >= 5'd1))
		else $error("date out of range");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(second_of_minute)
			&& $stable(minute_of_hour) && $stable(hour_of_day) && $stable(weekday)
			&& $stable(full_year) && $stable(month_number) && $stable(day_of_month))
		else $error("stalled result changed or dropped");

endmodule

bind epoch_seconds_to_calendar_core e2c_checker u_e2c_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (timestamp.valid),
	.in_ready         (timestamp.ready),
	.out_valid        (calendar.valid),
	.out_ready        (calendar.ready),
	.second_of_minute (calendar.second_of_minute),
	.minute_of_hour   (calendar.minute_of_hour),
	.hour_of_day      (calendar.hour_of_day),
	.weekday          (calendar.weekday),
	.full_year        (calendar.full_year),
	.month_number     (calendar.month_number),
	.day_of_month     (calendar.day_of_month)
);
`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for the epoch-seconds to calendar core: directed table, then random timestamps.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import e2c_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 800;
	localparam int unsigned QUIET_LIMIT     = 5000;
	localparam int unsigned DRAIN_CYCLES    = 200;
	localparam int unsigned EPOCH_YEAR      = 1970;
	// 1970-01-01 was a Thursday
	localparam int unsigned EPOCH_WEEKDAY   = 4;
	localparam int unsigned SECS_PER_DAY    = 86400;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [31:0] stamp;
		logic        typed;
		e2c_res_t    want;
	} stamp_row_t;

	typedef struct packed {
		logic [31:0] stamp;
		e2c_res_t    want;
	} calendar_due_t;

	// Rows with a typed result are read straight off the calendar
	localparam int unsigned DIRECTED_ROWS = 22;
	localparam stamp_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{32'd0,          1'b1, {6'd0, 6'd0, 5'd0, 3'd4, 12'd1970, 4'd1, 5'd1}},
		'{32'hFFFFFFFF,   1'b1, {6'd15, 6'd28, 5'd6, 3'd0, 12'd2106, 4'd2, 5'd7}},
		'{32'd86400,      1'b1, {6'd0, 6'd0, 5'd0, 3'd5, 12'd1970, 4'd1, 5'd2}},
		'{32'd31535999,   1'b1, {6'd59, 6'd59, 5'd23, 3'd4, 12'd1970, 4'd12, 5'd31}},
		'{32'd59,         1'b0, '0},
		'{32'd60,         1'b0, '0},
		'{32'd3599,       1'b0, '0},
		'{32'd3600,       1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		'{32'd63071999,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd946684799,  1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd4107456000, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		'{32'd4133980799, 1'b0, '0},
		'{32'd4291747200, 1'b0, '0},
		'{32'h7FFFFFFF,   1'b0, '0},
		'{32'hAAAAAAAA,   1'b0, '0},
		'{32'h55555555,   1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic [31:0] req_stamp = '0;
	logic result_ready = 1'b0;

	e2c_in_if  stamp_ch ();
	e2c_out_if calendar_ch ();

	assign stamp_ch.valid         = req_valid;
	assign stamp_ch.epoch_seconds = req_stamp;
	assign calendar_ch.ready      = result_ready;

	epoch_seconds_to_calendar_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.timestamp(stamp_ch),
		.calendar (calendar_ch)
	);

	calendar_due_t calendar_due [$];
	int unsigned   fail_count = 0;
	int unsigned   sent_count = 0;
	int unsigned   checked_count = 0;
	int unsigned   quiet_cycles = 0;
	int unsigned   ready_hold = 0;
	bit            steady = 1'b0;
	bit            leap_seen = 1'b0;
	bit            century_seen = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gregorian leap rule, centuries excepted unless divisible by 400
	function automatic bit is_leap_year(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int unsigned year_length(input int unsigned yr);
		return is_leap_year(yr) ? 366 : 365;
	endfunction

	// Month numbered 1..12
	function automatic int unsigned month_len_of(input int unsigned yr, input int unsigned mo);
		return (mo == 2 && is_leap_year(yr)) ? 29 : MONTH_LEN[mo - 1];
	endfunction

	function automatic e2c_res_t calendar_of(input logic [31:0] stamp);
		e2c_res_t    cal;
		int unsigned rest;
		int unsigned days;
		int unsigned yr;
		int unsigned mo;
		rest = stamp;
		cal.second_of_minute = 6'(rest % 60);
		rest = rest / 60;
		cal.minute_of_hour = 6'(rest % 60);
		rest = rest / 60;
		cal.hour_of_day = 5'(rest % 24);
		days = rest / 24;
		cal.weekday = 3'((days + EPOCH_WEEKDAY) % 7);
		// Walk whole years, then whole months
		yr = EPOCH_YEAR;
		while (days >= year_length(yr)) begin
			days = days - year_length(yr);
			yr++;
		end
		mo = 1;
		while (mo < 12 && days >= month_len_of(yr, mo)) begin
			days = days - month_len_of(yr, mo);
			mo++;
		end
		cal.full_year = 12'(yr);
		cal.month_number = 4'(mo);
		cal.day_of_month = 5'(days + 1);
		return cal;
	endfunction

	// Mostly short gaps, a few long ones, none in steady stretches
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (roll < 80)
			return $urandom_range(0, 3);
		if (roll < 95)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] stamp,
		input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch for stamp %0d: expected %0d, actual %0d",
				$time, name, stamp, want, got);
			fail_count++;
		end
	endfunction

	// Drive one request after a random gap and hold it until accepted
	task automatic send_stamp(input logic [31:0] stamp, input bit typed, input e2c_res_t want);
		int unsigned gap;
		calendar_due_t due;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_stamp <= stamp;
		@(posedge clk);
		while (!stamp_ch.ready) @(posedge clk);
		due.stamp = stamp;
		due.want = typed ? want : calendar_of(stamp);
		if (is_leap_year(due.want.full_year) && due.want.month_number == 4'd2
			&& due.want.day_of_month == 5'd29)
			leap_seen = 1'b1;
		if (due.want.full_year == 12'd2100)
			century_seen = 1'b1;
		calendar_due.push_back(due);
		sent_count++;
	endtask

	// Drop valid and hold until every pending result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (calendar_due.size() != 0) @(posedge clk);
	endtask

	// Result side stalls
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (steady) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(0, 3) != 0);
			ready_hold <= pick_gap();
		end
	end

	// Compare each result with the oldest pending expectation
	always @(posedge clk) begin
		calendar_due_t due;
		if (arst_n && calendar_ch.valid && calendar_ch.ready) begin
			if (calendar_due.size() == 0) begin
				$display("%0t: unexpected result: year %0d month %0d day %0d", $time,
					calendar_ch.full_year, calendar_ch.month_number, calendar_ch.day_of_month);
				fail_count++;
			end else begin
				due = calendar_due.pop_front();
				check_field("second", due.stamp, due.want.second_of_minute,
					calendar_ch.second_of_minute);
				check_field("minute", due.stamp, due.want.minute_of_hour,
					calendar_ch.minute_of_hour);
				check_field("hour", due.stamp, due.want.hour_of_day, calendar_ch.hour_of_day);
				check_field("weekday", due.stamp, due.want.weekday, calendar_ch.weekday);
				check_field("year", due.stamp, due.want.full_year, calendar_ch.full_year);
				check_field("month", due.stamp, due.want.month_number, calendar_ch.month_number);
				check_field("day", due.stamp, due.want.day_of_month, calendar_ch.day_of_month);
				checked_count++;
			end
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (stamp_ch.valid && stamp_ch.ready)
			|| (calendar_ch.valid && calendar_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired, %0d results still pending", $time,
				calendar_due.size());
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned kind;
		int unsigned yr;
		int unsigned mo;
		int unsigned first_day;
		longint      secs;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_stamp(DIRECTED[i].stamp, DIRECTED[i].typed, DIRECTED[i].want);
		end
		drain_results();

		// Random timestamps, biased toward calendar boundaries
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady = ((i / 100) % 4 == 2);
			if (i == RANDOM_REQUESTS / 2)
				drain_results();
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				secs = $urandom;
			end else if (kind < 65) begin
				// Near the first of a month, a few seconds or a day either side
				yr = $urandom_range(EPOCH_YEAR, 2106);
				mo = (yr == 2106) ? $urandom_range(1, 2) : $urandom_range(1, 12);
				first_day = 0;
				for (int y = EPOCH_YEAR; y < yr; y++) first_day += year_length(y);
				for (int m = 1; m < mo; m++) first_day += month_len_of(yr, m);
				secs = longint'(first_day) * SECS_PER_DAY + longint'($urandom_range(0, 6)) - 3
					+ (longint'($urandom_range(0, 2)) - 1) * SECS_PER_DAY;
			end else if (kind < 80) begin
				// Last seconds of a day
				secs = longint'($urandom_range(0, 49709)) * SECS_PER_DAY + SECS_PER_DAY - 1
					- $urandom_range(0, 3);
			end else if (kind < 90) begin
				secs = $urandom_range(0, 200000);
			end else begin
				secs = 64'hFFFFFFFF - $urandom_range(0, SECS_PER_DAY * 400);
			end
			if (secs < 0)
				secs = 0;
			if (secs > 64'hFFFFFFFF)
				secs = 64'hFFFFFFFF;
			send_stamp(32'(secs), 1'b0, '0);
		end
		steady = 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (calendar_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, calendar_due.size());
			fail_count++;
		end
		$display("summary: %0d requests sent, %0d results checked, %0d mismatches",
			sent_count, checked_count, fail_count);
		$display("summary: leap day hit %0d, year 2100 hit %0d, full 32-bit range swept",
			leap_seen, century_seen);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
design/e2c_pkg.sv
design/e2c_in_if.sv
design/e2c_out_if.sv
design/e2c_datapath.sv
design/e2c_controller.sv
design/epoch_seconds_to_calendar_core.sv
design/e2c_checker.sv
dv/testbench.sv
